/* hw/rtl/lwf_pkg.sv */
// Package for the lock-wait FIFO: payload structs, op and status codes, sizes.
// No dependencies.
`default_nettype none
package lwf_pkg;
    localparam int unsigned MaxEntries = 64;
    localparam int unsigned AddrW = $clog2(MaxEntries);
    localparam int unsigned CountW = $clog2(MaxEntries + 1);

    typedef enum logic [2:0] {
        OP_INSERT       = 3'd0,
        OP_POP          = 3'd1,
        OP_PEEK         = 3'd2,
        OP_REMOVE_MATCH = 3'd3,
        OP_REMOVE_ALL   = 3'd4
    } t_op;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] seq_number;
        logic [31:0]        target_node;
        logic [31:0]        owner_node;
        logic [31:0]        owner_user;
        logic [7:0]         lock_type;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] head_seq;
        logic [31:0]        head_target_node;
        logic [31:0]        head_owner_node;
        logic [31:0]        head_owner_user;
        logic [7:0]         head_lock_type;
        logic [6:0]         removed_count;
        logic [6:0]         occupancy;
    } t_out_item;

    // One stored record.
    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] target_node;
        logic [31:0] owner_node;
        logic [31:0] owner_user;
        logic [7:0]  lock_type;
    } t_entry;
endpackage
`default_nettype wire

/* hw/rtl/lock_wait_fifo_with_match_removal_top.sv */
// Top level of the lock-wait FIFO with selective removal: sequencer and result register.
// Depends on lwf_pkg and lwf_ram.
//
//   Channel | Signals                          | Payload
//   input   | i_in_valid, o_in_ready           | i_in_item  (lwf_pkg::t_in_item)
//   output  | o_out_valid, i_out_ready         | o_out_item (lwf_pkg::t_out_item)
//
// Insert, remove-all and unused ops finish in the idle state; pop and peek also pass
// through a read state, since the record memory read is registered. Remove-matching walks
// the held records one per cycle through the single read port, then checks the last read
// data, sees the walk drained and closes out in a done state. The result waits in an
// output register; the next item is taken once that register is free. Reset is
// synchronous and clears the pointers, count and handshake state; the record
// memory needs no clearing.
`default_nettype none
module lock_wait_fifo_with_match_removal_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire lwf_pkg::t_in_item  i_in_item,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output lwf_pkg::t_out_item      o_out_item
);
    localparam int unsigned AW = lwf_pkg::AddrW;
    localparam int unsigned CW = lwf_pkg::CountW;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    lwf_pkg::t_in_item  r_cmd, n_cmd;
    logic [CW-1:0]      r_rd_idx, n_rd_idx;   // next record offset to read
    logic [CW-1:0]      r_chk_idx, n_chk_idx; // offset of record in read data
    logic               r_chk_vld, n_chk_vld;
    logic [CW-1:0]      r_wr_idx, n_wr_idx;   // compaction write offset
    logic               r_out_valid, n_out_valid;
    lwf_pkg::t_out_item r_out, n_out;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    lwf_pkg::t_entry    wdata, rdata;

    lwf_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Slot of an offset from the head, modulo the depth.
    function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = {1'b0, {(CW-AW){1'b0}}, head} + {1'b0, off};
        if (sum >= (CW+1)'(lwf_pkg::MaxEntries)) begin
            sum = sum - (CW+1)'(lwf_pkg::MaxEntries);
        end
        return sum[AW-1:0];
    endfunction

    always_comb begin
        logic match;
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_cmd       = r_cmd;
        n_rd_idx    = r_rd_idx;
        n_chk_idx   = r_chk_idx;
        n_chk_vld   = 1'b0;
        n_wr_idx    = r_wr_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        we          = 1'b0;
        waddr       = slot(r_head, r_count);
        wdata       = {i_in_item.seq_number, i_in_item.target_node,
                       i_in_item.owner_node, i_in_item.owner_user,
                       i_in_item.lock_type};
        raddr       = r_head;
        match       = (rdata.owner_node == r_cmd.owner_node)
                      && (rdata.lock_type == r_cmd.lock_type);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_cmd = i_in_item;
                    n_out = '0;
                    n_out.occupancy = 7'(r_count);
                    n_out_valid = 1'b1;
                    unique case (i_in_item.op)
                        lwf_pkg::OP_INSERT: begin
                            if (r_count == CW'(lwf_pkg::MaxEntries)) begin
                                n_out.status = lwf_pkg::ST_FULL;
                            end else begin
                                we = 1'b1;
                                n_count = r_count + 1'b1;
                                n_out.occupancy = 7'(r_count + 1'b1);
                            end
                        end
                        lwf_pkg::OP_POP, lwf_pkg::OP_PEEK: begin
                            if (r_count == '0) begin
                                n_out.status = lwf_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state = S_READ;
                            end
                        end
                        lwf_pkg::OP_REMOVE_MATCH: begin
                            n_out_valid = 1'b0;
                            n_rd_idx  = '0;
                            n_wr_idx  = '0;
                            n_state   = S_SCAN;
                        end
                        lwf_pkg::OP_REMOVE_ALL: begin
                            n_count = '0;
                            n_out.occupancy = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_READ: begin
                // Read data for the head slot is valid in this cycle.
                n_out.head_seq         = rdata.seq;
                n_out.head_target_node = rdata.target_node;
                n_out.head_owner_node  = rdata.owner_node;
                n_out.head_owner_user  = rdata.owner_user;
                n_out.head_lock_type   = rdata.lock_type;
                if (r_cmd.op == lwf_pkg::OP_POP) begin
                    n_head  = slot(r_head, CW'(1));
                    n_count = r_count - 1'b1;
                    n_out.occupancy = 7'(r_count - 1'b1);
                end
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            S_SCAN: begin
                // Issue one read per cycle; check the previous one's data.
                raddr = slot(r_head, r_rd_idx);
                if (r_rd_idx < r_count) begin
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_chk_idx = r_rd_idx;
                    n_chk_vld = 1'b1;
                end
                if (r_chk_vld) begin
                    if (match) begin
                        n_out.removed_count = n_out.removed_count + 1'b1;
                    end else begin
                        we       = (r_wr_idx != r_chk_idx);
                        waddr    = slot(r_head, r_wr_idx);
                        wdata    = rdata;
                        n_wr_idx = r_wr_idx + 1'b1;
                    end
                end
                if (!r_chk_vld && r_rd_idx >= r_count) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_count = r_wr_idx;
                n_out.occupancy = 7'(r_wr_idx);
                n_out_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_chk_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            r_chk_vld   <= n_chk_vld;
        end
        r_cmd     <= n_cmd;
        r_rd_idx  <= n_rd_idx;
        r_chk_idx <= n_chk_idx;
        r_wr_idx  <= n_wr_idx;
        r_out     <= n_out;
    end
endmodule
`default_nettype wire

/* hw/rtl/lwf_ram.sv */
// Record storage: one write port, one registered read port.
// Depends on lwf_pkg.
`default_nettype none
module lwf_ram (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [lwf_pkg::AddrW-1:0]  i_waddr,
    input  wire lwf_pkg::t_entry            i_wdata,
    input  wire logic [lwf_pkg::AddrW-1:0]  i_raddr,
    output lwf_pkg::t_entry                 o_rdata
);
    lwf_pkg::t_entry r_mem [lwf_pkg::MaxEntries];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* dv/lwf_checker.sv */
// Checker for the lock-wait FIFO: watches both channels, predicts each result from
// accepted items and compares field by field. Depends on lwf_pkg.
`default_nettype none
module lwf_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_in_ready,
    input  wire lwf_pkg::t_in_item  i_in_item,
    input  wire logic               i_out_valid,
    input  wire logic               i_out_ready,
    input  wire lwf_pkg::t_out_item i_out_item,
    output int                      o_errors,
    output int                      o_pending
);
    import lwf_pkg::*;

    t_entry        recs[MaxEntries];
    int unsigned   head_slot;
    int unsigned   held;
    t_out_item     results_due[$];

    function automatic t_out_item apply_op(t_in_item it);
        t_out_item r;
        int unsigned keep;
        int unsigned gone;
        int unsigned s;
        r = '0;
        gone = 0;
        case (it.op)
            OP_INSERT: begin
                if (held >= MaxEntries) begin
                    r.status = ST_FULL;
                end else begin
                    recs[(head_slot + held) % MaxEntries] =
                        {it.seq_number, it.target_node, it.owner_node, it.owner_user,
                         it.lock_type};
                    held++;
                end
            end
            OP_POP, OP_PEEK: begin
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.head_seq         = recs[head_slot].seq;
                    r.head_target_node = recs[head_slot].target_node;
                    r.head_owner_node  = recs[head_slot].owner_node;
                    r.head_owner_user  = recs[head_slot].owner_user;
                    r.head_lock_type   = recs[head_slot].lock_type;
                    if (it.op == OP_POP) begin
                        head_slot = (head_slot + 1) % MaxEntries;
                        held--;
                    end
                end
            end
            OP_REMOVE_MATCH: begin
                keep = 0;
                for (int unsigned k = 0; k < held; k++) begin
                    s = (head_slot + k) % MaxEntries;
                    if (recs[s].owner_node == it.owner_node &&
                        recs[s].lock_type == it.lock_type) begin
                        gone++;
                    end else begin
                        recs[(head_slot + keep) % MaxEntries] = recs[s];
                        keep++;
                    end
                end
                held = keep;
            end
            OP_REMOVE_ALL: held = 0;
            default: ;
        endcase
        r.removed_count = gone[6:0];
        r.occupancy     = held[6:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            head_slot = 0;
            held      = 0;
            o_errors  <= 0;
            results_due.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_out_item);
                    o_errors <= o_errors + 1;
                end else begin
                    want = results_due[0];
                    results_due.delete(0);
                    if (want !== i_out_item) begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $time, want, i_out_item);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                results_due.insert(results_due.size(), apply_op(i_in_item));
            end
            o_pending <= results_due.size();
        end
    end
endmodule
`default_nettype wire

/* dv/tb_lock_wait_fifo_with_match_removal_top.sv */
// Testbench top for the lock-wait FIFO: clock, reset, stimulus and verdict.
// Depends on lwf_pkg, lwf_checker and the block under test.
`default_nettype none
module tb_lock_wait_fifo_with_match_removal_top;
    import lwf_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_item;
    int        errors;
    int        pending;
    int        cycles = 0;
    // While set, the receiver refuses every result so the block backs up.
    bit        hold_results = 1'b0;

    // Small key pools make matches and repeated owners common.
    logic [31:0] node_keys[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001};
    logic [7:0]  type_keys[3] = '{8'h00, 8'hFF, 8'h5A};

    always #5 clk = ~clk;

    lock_wait_fifo_with_match_removal_top i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_item(out_item)
    );

    lwf_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_item(out_item),
        .o_errors(errors), .o_pending(pending)
    );

    // The run is bounded: the limit leaves ample margin over the longest walk
    // and the random gaps on both channels for each item.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Offer one item, then wait for the handshake. Valid stays up with a fixed
    // payload until it is taken. Entered and left at a falling edge; valid is
    // dropped only when a gap follows, so back-to-back items keep it high.
    task automatic send_item(input t_in_item it, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic t_in_item make_item(input logic [2:0] op, input bit keyed);
        t_in_item it;
        it.op          = op;
        it.seq_number  = $urandom;
        it.target_node = $urandom;
        it.owner_user  = $urandom;
        it.owner_node  = keyed ? node_keys[$urandom_range(0, 3)] : $urandom;
        it.lock_type   = keyed ? type_keys[$urandom_range(0, 2)]
                               : 8'($urandom_range(0, 255));
        return it;
    endfunction

    // Receiver: a random stall before each result, unless a long hold is on.
    initial begin
        int stall;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (stall != 0 || hold_results) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
                while (hold_results) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    initial begin
        t_in_item it;
        int unsigned pick;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty queue cases, field extremes, every op, fill to full.
        send_item(make_item(OP_POP, 1'b0), 1'b0);
        send_item(make_item(OP_PEEK, 1'b0), 1'b0);
        send_item(make_item(OP_REMOVE_MATCH, 1'b1), 1'b0);
        it = '1;
        it.op = OP_INSERT;
        send_item(it, 1'b0);
        it = '0;
        it.op = OP_INSERT;
        send_item(it, 1'b0);
        send_item(make_item(OP_PEEK, 1'b0), 1'b0);
        send_item(make_item(OP_POP, 1'b0), 1'b0);
        send_item(make_item(OP_POP, 1'b0), 1'b0);
        it = '1;
        for (int op = 5; op < 8; op++) begin
            it.op = op[2:0];
            send_item(it, 1'b0);
        end
        // Fill past capacity with the receiver held off, so the block stalls.
        hold_results = 1'b1;
        fork
            begin
                repeat (300) @(negedge clk);
                hold_results = 1'b0;
            end
        join_none
        for (int k = 0; k < 66; k++) send_item(make_item(OP_INSERT, 1'b1), 1'b1);
        send_item(make_item(OP_REMOVE_MATCH, 1'b1), 1'b0);
        send_item(make_item(OP_REMOVE_ALL, 1'b0), 1'b0);
        // Pause until every result is back.
        in_valid <= 1'b0;
        while (pending != 0 || hold_results) @(negedge clk);

        // Random: mostly inserts and reads on keyed records, with some noise.
        for (int n = 0; n < 1350; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      it = make_item(OP_INSERT, 1'b1);
            else if (pick < 65) it = make_item(OP_POP, 1'b0);
            else if (pick < 78) it = make_item(OP_PEEK, 1'b0);
            else if (pick < 92) it = make_item(OP_REMOVE_MATCH, $urandom_range(0, 4) != 0);
            else if (pick < 95) it = make_item(OP_REMOVE_ALL, 1'b0);
            else begin
                it = make_item(OP_INSERT, 1'b0);
                it.op = 3'($urandom_range(5, 7));
            end
            send_item(it, $urandom_range(0, 4) == 0);
        end

        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* lock_wait_fifo_with_match_removal_top.f */
hw/rtl/lwf_pkg.sv
hw/rtl/lwf_ram.sv
hw/rtl/lock_wait_fifo_with_match_removal_top.sv
dv/lwf_checker.sv
dv/tb_lock_wait_fifo_with_match_removal_top.sv
